/* hdl/hsn_pkg.sv */
// ----------------------------------------------------------------------------
// hsn_pkg
// Shared types, constants and the sine table generator for the harmonic NCO.
// ----------------------------------------------------------------------------
package hsn_pkg;

  localparam int PHASE_W           = 32;
  localparam int TABLE_DEPTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  // phases of the three harmonics for one tick
  typedef struct packed {
    logic [PHASE_W-1:0] p3;
    logic [PHASE_W-1:0] p2;
    logic [PHASE_W-1:0] p1;
  } phase_set_t;

  // taylor term divisor (2n)(2n+1)
  function automatic logic [63:0] taylor_div(input logic [63:0] term, input int unsigned n);
    logic [63:0] res;
    case (n)
      1:       res = term / 64'd6;
      2:       res = term / 64'd20;
      3:       res = term / 64'd42;
      4:       res = term / 64'd72;
      5:       res = term / 64'd110;
      6:       res = term / 64'd156;
      7:       res = term / 64'd210;
      8:       res = term / 64'd272;
      9:       res = term / 64'd342;
      10:      res = term / 64'd420;
      default: res = term;
    endcase
    return res;
  endfunction

  // sine table entry i for a table of 2^lg entries, amplitude 2^(sb-1)-1
  function automatic longint sine_entry(input int unsigned i, input int unsigned lg,
                                        input int unsigned sb);
    logic [63:0]  k;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  amp;
    logic [63:0]  scaled;
    longint       sum;
    longint       v;
    int unsigned  ql;
    int unsigned  quad;
    ql   = lg - 2;
    quad = i >> ql;
    k    = 64'(i) & ((64'd1 << ql) - 64'd1);
    if (quad[0]) begin
      k = (64'd1 << ql) - k;
    end
    amp  = (64'd1 << (sb - 1)) - 64'd1;
    x    = (HALF_PI_Q30 * k + (64'd1 << (ql - 1))) >> ql;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int unsigned n = 1; n <= 10; n++) begin
      term = (term * x2) >> 30;
      term = taylor_div(term, n);
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    scaled = (64'(sum) * amp + (ONE_Q30 >> 1)) >> 30;
    v      = longint'(scaled);
    if (quad[1]) begin
      v = -v;
    end
    return v;
  endfunction

endpackage

/* hdl/hsn_queue.sv */
// ----------------------------------------------------------------------------
// hsn_queue
// Short first-in first-out buffer of phase sets between front and back.
// ----------------------------------------------------------------------------
module hsn_queue
  import hsn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  phase_set_t        push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output phase_set_t        pop_data,
  output logic [QCNT_W-1:0] count
);

  phase_set_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];
  assign count     = count_r;
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/hsn_front.sv */
// ----------------------------------------------------------------------------
// hsn_front
// Accepts tick transfers, keeps the phase accumulator and forms the three
// harmonic phases for the queue.
// ----------------------------------------------------------------------------
module hsn_front
  import hsn_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [PHASE_W-1:0] cfg_wr_data,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               restart,
  input  logic               q_full,
  output logic               q_push,
  output phase_set_t         q_data
);

  logic [PHASE_W-1:0] phase_inc_r;
  logic [PHASE_W-1:0] acc_r, acc_nxt;
  logic [PHASE_W-1:0] phase;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // restart clears the phase ahead of this sample
  assign phase     = restart ? '0 : acc_r;
  assign q_data.p1 = phase;
  assign q_data.p2 = phase << 1;
  assign q_data.p3 = phase + (phase << 1);
  assign acc_nxt   = q_push ? phase + phase_inc_r : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      acc_r       <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (cfg_wr_en) begin
        phase_inc_r <= cfg_wr_data;
      end
    end
  end

endmodule

/* hdl/hsn_lane.sv */
// ----------------------------------------------------------------------------
// hsn_lane
// One harmonic: sine table lookup of two neighbor entries, interpolation
// multiply, then round, add and saturate into the sample register.
// ----------------------------------------------------------------------------
module hsn_lane
  import hsn_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [PHASE_W-1:0]            phase,
  output logic signed [SAMPLE_BITS-1:0] sample
);

  localparam int L    = $clog2(TABLE_DEPTH);
  localparam int F    = PHASE_W - L;
  localparam int DW   = SAMPLE_BITS + 1;
  localparam int PW   = SAMPLE_BITS + F + 3;
  localparam int VW   = SAMPLE_BITS + 3;
  localparam logic signed [PW-1:0] RND  = PW'(1) << (F - 1);
  localparam logic signed [VW-1:0] VMAX = (VW'(1) << (SAMPLE_BITS - 1)) - VW'(1);
  localparam logic signed [VW-1:0] VMIN = -(VW'(1) << (SAMPLE_BITS - 1));

  typedef logic signed [SAMPLE_BITS-1:0] rom_t [TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      r[i] = SAMPLE_BITS'(sine_entry(i, L, SAMPLE_BITS));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [L-1:0]                  idx;
  logic [L-1:0]                  idx_next;
  logic signed [SAMPLE_BITS-1:0] s0_r;
  logic signed [SAMPLE_BITS-1:0] s1_r;
  logic [F-1:0]                  frac_r;
  logic signed [SAMPLE_BITS-1:0] s0_d_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [DW-1:0]          diff;
  logic signed [PW-1:0]          prod_nxt;
  logic signed [PW-1:0]          t;
  logic signed [VW-1:0]          v;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;

  assign idx      = phase[PHASE_W-1 -: L];
  assign idx_next = idx + L'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r   <= SINE_ROM[idx];
      s1_r   <= SINE_ROM[idx_next];
      frac_r <= phase[F-1:0];
    end
  end

  assign diff     = DW'(s1_r) - DW'(s0_r);
  assign prod_nxt = PW'(diff * $signed({1'b0, frac_r}));

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      s0_d_r <= s0_r;
    end
  end

  // arithmetic shift gives the floor of the rounded quotient
  always_comb begin
    t = prod_r + RND;
    v = VW'(s0_d_r) + VW'(t >>> F);
    if (v > VMAX) begin
      sample_nxt = SAMPLE_BITS'(VMAX);
    end else if (v < VMIN) begin
      sample_nxt = SAMPLE_BITS'(VMIN);
    end else begin
      sample_nxt = SAMPLE_BITS'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_r <= sample_nxt;
    end
  end

  assign sample = sample_r;

endmodule

/* hdl/hsn_back.sv */
// ----------------------------------------------------------------------------
// hsn_back
// Drains the phase queue through three harmonic lanes into the output
// register; the whole pipe holds while a result waits on the sink.
// ----------------------------------------------------------------------------
module hsn_back
  import hsn_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  phase_set_t                    q_data,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic signed [SAMPLE_BITS-1:0] pilot,
  output logic signed [SAMPLE_BITS-1:0] subcarrier,
  output logic signed [SAMPLE_BITS-1:0] third
);

  logic adv;
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;

  assign adv   = !v3_r || out_tready;
  assign q_pop = adv;

  always_comb begin
    v1_nxt = adv ? q_valid : v1_r;
    v2_nxt = adv ? v1_r    : v2_r;
    v3_nxt = adv ? v2_r    : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  assign out_tvalid = v3_r;

  hsn_lane #(.TABLE_DEPTH(TABLE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_lane1 (
    .clk    (clk),
    .en     (adv),
    .phase  (q_data.p1),
    .sample (pilot)
  );

  hsn_lane #(.TABLE_DEPTH(TABLE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_lane2 (
    .clk    (clk),
    .en     (adv),
    .phase  (q_data.p2),
    .sample (subcarrier)
  );

  hsn_lane #(.TABLE_DEPTH(TABLE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_lane3 (
    .clk    (clk),
    .en     (adv),
    .phase  (q_data.p3),
    .sample (third)
  );

endmodule

/* hdl/harmonic_sine_nco.sv */
// Path: a tick accepted into the queue passes the table read, multiply and
//   round/saturate registers in turn before its result shows on out_tvalid.
// Throughput: one tick per cycle, sustained while out_tready stays high; the
//   dual-read sine table of each harmonic lane is read once per cycle.
// Reset: rst_n synchronous active low clears phase, increment, queue and pipe
//   valids; the sine table is constant and needs no fill.
// ----------------------------------------------------------------------------
// harmonic_sine_nco
// Phase-accumulating oscillator giving fundamental, 2x and 3x sine samples
// with table interpolation, split into a front, a queue and a back end.
// ----------------------------------------------------------------------------
module harmonic_sine_nco
  import hsn_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [PHASE_W-1:0]                      cfg_wr_data,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // [0] restart_phase, [7:1] zero
  input  logic [7:0]                              in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // pilot_sample, subcarrier_sample, third_harmonic_sample from bit 0, zero fill
  output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]      out_tdata
);

  localparam int OUT_W = ((3 * SAMPLE_BITS + 7) / 8) * 8;

  logic                          q_full;
  logic                          q_push;
  phase_set_t                    q_push_data;
  logic                          q_pop;
  logic                          q_valid;
  phase_set_t                    q_pop_data;
  logic [QCNT_W-1:0]             q_count;
  logic signed [SAMPLE_BITS-1:0] pilot;
  logic signed [SAMPLE_BITS-1:0] subcarrier;
  logic signed [SAMPLE_BITS-1:0] third;

  hsn_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .restart     (in_tdata[0]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  hsn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_pop_data),
    .count     (q_count)
  );

  hsn_back #(.TABLE_DEPTH(TABLE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_pop_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .pilot      (pilot),
    .subcarrier (subcarrier),
    .third      (third)
  );

  assign out_tdata = OUT_W'({third, subcarrier, pilot});

`ifndef SYNTHESIS
  a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("phase queue count beyond depth");

  a_push_not_full : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("transfer accepted into a full queue");

  a_restart_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_tdata[0]) |-> (q_push_data == '0))
    else $error("restart tick did not start from phase zero");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !(q_pop && q_valid)) |=> (q_count == $past(q_count) + QCNT_W'(1)))
    else $error("queue count did not follow a lone push");
`endif

endmodule
